// ===== src/ron_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ron_pkg
// Shared types, constants and helpers of the running observation normalizer.
// -----------------------------------------------------------------------------
package ron_pkg;

   localparam int NUM_ELEMENTS = 4;
   localparam int IDX_W        = 2;
   localparam int COUNT_W      = 32;
   localparam int MEAN_W       = 32;
   localparam int SUM_W        = 48;
   localparam int NORM_W       = 17;
   localparam int DIV_NUM_W    = 64;
   localparam int DIV_DEN_W    = 34;
   localparam int ROOT_W       = 32;
   localparam int MAG_W        = 48;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
   localparam logic [SUM_W-1:0]   SUM_RESET  = 48'h0000_0001_0000;
   localparam logic [SUM_W-1:0]   SUM_MAX    = 48'hFFFF_FFFF_FFFF;
   localparam logic [MAG_W-1:0]   DIFF_MAX   = 48'h8000_0000_0000;
   localparam logic [31:0]        PROD_MAX   = 32'hFFFF_FFFF;
   localparam logic [NORM_W-1:0]  OUT_LIMIT  = 17'd40960;

   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DIV_MEAN = 2'd0;
   localparam div_sel_type DIV_VAR  = 2'd1;
   localparam div_sel_type DIV_OUT  = 2'd2;

   typedef struct packed {
      logic              load;
      logic              count_inc;
      logic              div_start;
      div_sel_type       div_sel;
      logic              mean_wr;
      logic              prod_en;
      logic              sum_wr;
      logic              q_wr;
      logic              sqrt_start;
      logic              sd_wr;
      logic              norm_skip_wr;
      logic              norm_div_wr;
      logic              publish;
      logic [IDX_W-1:0]  idx;
   } ron_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic sqrt_busy;
      logic sqrt_done;
      logic skip;
   } ron_sts_type;

   // Clamps a magnitude to the output limit and applies the sign.
   function automatic logic signed [NORM_W-1:0] clamp_norm(input logic neg,
                                                           input logic [DIV_NUM_W-1:0] r);
      logic [NORM_W-1:0] m;
      m = (r > DIV_NUM_W'(OUT_LIMIT)) ? OUT_LIMIT : r[NORM_W-1:0];
      return neg ? -$signed(m) : $signed(m);
   endfunction

endpackage
`default_nettype wire

// ===== src/ron_div.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ron_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// -----------------------------------------------------------------------------
module ron_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ron_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [ron_pkg::DIV_DEN_W-1:0] den,
   output logic                               busy,
   output logic                               done,
   output logic [ron_pkg::DIV_NUM_W-1:0]      quot
);
   import ron_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] n_ff, n_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, n_ff[DIV_NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      n_in    = n_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The quotient bits shift into the numerator register as it empties.
         n_in   = {n_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = n_ff;

endmodule
`default_nettype wire

// ===== src/ron_sqrt.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ron_sqrt
// Integer square root, floor, one result bit per cycle.
// -----------------------------------------------------------------------------
module ron_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ron_pkg::DIV_NUM_W-1:0] value,
   output logic                               busy,
   output logic                               done,
   output logic [ron_pkg::ROOT_W-1:0]         root
);
   import ron_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W + 1);
   localparam int REM_W = ROOT_W + 2;

   logic [DIV_NUM_W-1:0] v_ff, v_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_W+1:0]     shifted;
   logic [REM_W+1:0]     trial;
   logic [REM_W+1:0]     diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, v_ff[DIV_NUM_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      ge      = shifted >= trial;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in    = {v_ff[DIV_NUM_W-3:0], 2'b00};
         rem_in  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== src/ron_dp.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ron_dp
// Datapath: statistics, per-element arithmetic, shared divider and root unit.
// -----------------------------------------------------------------------------
module ron_dp #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ron_pkg::ron_cmd_type             cmd,
   output ron_pkg::ron_sts_type                  sts,
   input  wire logic signed [SAMPLE_WIDTH-1:0]   sample_in [ron_pkg::NUM_ELEMENTS],
   output logic signed [ron_pkg::NORM_W-1:0]     norm_out [ron_pkg::NUM_ELEMENTS],
   output logic                                  skip_out
);
   import ron_pkg::*;

   localparam int XW = SAMPLE_WIDTH + 16;
   localparam int DW = ((XW > MEAN_W) ? XW : MEAN_W) + 1;
   localparam int EW = (DW > MAG_W + 1) ? DW : MAG_W + 1;

   logic signed [SAMPLE_WIDTH-1:0] x_ff [NUM_ELEMENTS];
   logic [COUNT_W-1:0]             count_ff;
   logic signed [MEAN_W-1:0]       mean_ff [NUM_ELEMENTS];
   logic [SUM_W-1:0]               sum_ff [NUM_ELEMENTS];
   logic [SUM_W-1:0]               q_ff [NUM_ELEMENTS];
   logic                           skip_ff;
   logic [DW-1:0]                  dm_ff;
   logic                           dneg_ff, dpos_ff;
   logic [63:0]                    p_ff;
   logic                           opp_ff;
   logic [ROOT_W-1:0]              sd_ff;
   logic signed [NORM_W-1:0]       norm_ff [NUM_ELEMENTS];
   logic signed [NORM_W-1:0]       rsp_norm_ff [NUM_ELEMENTS];
   logic                           rsp_skip_ff;

   logic signed [XW-1:0]  xq;
   logic signed [DW-1:0]  diff;
   logic                  dneg;
   logic [DW-1:0]         dmag;
   logic [EW-1:0]         dmag_e;
   logic [MAG_W-1:0]      mo;
   logic signed [DW:0]    nm;
   logic signed [MEAN_W-1:0] nm_sat;
   logic [31:0]           m1, m2;
   logic [SUM_W:0]        pr;
   logic [SUM_W+1:0]      acc;
   logic [SUM_W-1:0]      sum_in;
   logic [MAG_W:0]        mo_rnd;

   logic                  div_start, div_busy, div_done;
   logic [DIV_NUM_W-1:0]  div_num, div_quot;
   logic [DIV_DEN_W-1:0]  div_den;
   logic                  sqrt_busy, sqrt_done;
   logic [ROOT_W-1:0]     sqrt_root;

   always_comb begin
      xq     = {x_ff[cmd.idx], 16'b0};
      diff   = DW'(xq) - DW'(mean_ff[cmd.idx]);
      dneg   = diff[DW-1];
      dmag   = dneg ? DW'(-diff) : DW'(diff);
      dmag_e = EW'(dmag);
      mo     = (dmag_e > EW'(DIFF_MAX)) ? DIFF_MAX : dmag_e[MAG_W-1:0];
      mo_rnd = {1'b0, mo} + (MAG_W+1)'(8);

      // New mean from the rounded quotient; saturate when the top bits disagree.
      nm = dneg_ff ? ((DW+1)'(mean_ff[cmd.idx]) - (DW+1)'(div_quot[DW-1:0]))
                   : ((DW+1)'(mean_ff[cmd.idx]) + (DW+1)'(div_quot[DW-1:0]));
      if ((nm[DW:MEAN_W-1] == '0) || (nm[DW:MEAN_W-1] == '1)) begin
         nm_sat = nm[MEAN_W-1:0];
      end else begin
         nm_sat = nm[DW] ? {1'b1, {(MEAN_W-1){1'b0}}} : {1'b0, {(MEAN_W-1){1'b1}}};
      end

      m1 = (dm_ff[DW-1:32] != '0) ? PROD_MAX : dm_ff[31:0];
      m2 = (dmag[DW-1:32] != '0) ? PROD_MAX : dmag[31:0];

      pr  = {1'b0, p_ff[63:16]} + (SUM_W+1)'(p_ff[15]);
      acc = (SUM_W+2)'(sum_ff[cmd.idx]) + (SUM_W+2)'(pr);
      if (opp_ff) begin
         sum_in = (pr > (SUM_W+1)'(sum_ff[cmd.idx])) ? '0
                : SUM_W'((SUM_W+1)'(sum_ff[cmd.idx]) - pr);
      end else begin
         sum_in = (acc > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
      end

      case (cmd.div_sel)
         DIV_VAR: begin
            div_num = DIV_NUM_W'(sum_ff[cmd.idx]);
            div_den = DIV_DEN_W'(count_ff);
         end
         DIV_OUT: begin
            div_num = DIV_NUM_W'({mo, 13'b0}) + DIV_NUM_W'(sd_ff);
            div_den = DIV_DEN_W'({sd_ff, 1'b0});
         end
         default: begin
            div_num = DIV_NUM_W'({dmag, 1'b0}) + DIV_NUM_W'(count_ff);
            div_den = DIV_DEN_W'({count_ff, 1'b0});
         end
      endcase
   end

   assign div_start = cmd.div_start;

   ron_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   ron_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value ({q_ff[cmd.idx], 16'b0}),
      .busy  (sqrt_busy),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= sample_in;
      end
      if (cmd.div_start && (cmd.div_sel == DIV_MEAN)) begin
         dm_ff   <= dmag;
         dneg_ff <= dneg;
         dpos_ff <= !dneg && (diff != '0);
      end
      if (cmd.prod_en) begin
         p_ff   <= 64'(m1) * 64'(m2);
         opp_ff <= (dneg_ff && !dneg && (diff != '0)) || (dpos_ff && dneg);
      end
      if (cmd.q_wr) begin
         q_ff[cmd.idx] <= div_quot[SUM_W-1:0];
      end
      if (cmd.sd_wr) begin
         sd_ff <= sqrt_root;
      end
      if (cmd.norm_skip_wr) begin
         norm_ff[cmd.idx] <= clamp_norm(dneg, DIV_NUM_W'(mo_rnd[MAG_W:4]));
      end
      if (cmd.norm_div_wr) begin
         norm_ff[cmd.idx] <= clamp_norm(dneg, div_quot);
      end
      if (cmd.publish) begin
         rsp_norm_ff <= norm_ff;
         rsp_skip_ff <= skip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
         skip_ff  <= 1'b0;
         for (int i = 0; i < NUM_ELEMENTS; i++) begin
            mean_ff[i] <= '0;
            sum_ff[i]  <= SUM_RESET;
         end
      end else begin
         if (cmd.count_inc && (count_ff != COUNT_MAX)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.load) begin
            skip_ff <= 1'b0;
         end else if (cmd.q_wr && (div_quot == '0)) begin
            skip_ff <= 1'b1;
         end
         if (cmd.mean_wr) begin
            mean_ff[cmd.idx] <= nm_sat;
         end
         if (cmd.sum_wr) begin
            sum_ff[cmd.idx] <= sum_in;
         end
      end
   end

   assign sts.div_busy  = div_busy;
   assign sts.div_done  = div_done;
   assign sts.sqrt_busy = sqrt_busy;
   assign sts.sqrt_done = sqrt_done;
   assign sts.skip      = skip_ff;
   assign norm_out      = rsp_norm_ff;
   assign skip_out      = rsp_skip_ff;

endmodule
`default_nettype wire

// ===== src/ron_ctrl.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// ron_ctrl
// Sequencer: walks the elements through update, variance, root and scaling.
// -----------------------------------------------------------------------------
module ron_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_update_stats,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ron_pkg::ron_cmd_type       cmd,
   input  wire ron_pkg::ron_sts_type  sts
);
   import ron_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_M_GO   = 4'd1;
   localparam logic [3:0] S_M_WAIT = 4'd2;
   localparam logic [3:0] S_M_MEAN = 4'd3;
   localparam logic [3:0] S_M_PROD = 4'd4;
   localparam logic [3:0] S_M_SUM  = 4'd5;
   localparam logic [3:0] S_Q_GO   = 4'd6;
   localparam logic [3:0] S_Q_WAIT = 4'd7;
   localparam logic [3:0] S_O_SEL  = 4'd8;
   localparam logic [3:0] S_O_SKIP = 4'd9;
   localparam logic [3:0] S_R_GO   = 4'd10;
   localparam logic [3:0] S_R_WAIT = 4'd11;
   localparam logic [3:0] S_D_GO   = 4'd12;
   localparam logic [3:0] S_D_WAIT = 4'd13;
   localparam logic [3:0] S_FIN    = 4'd14;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last;

   always_comb begin
      last         = (idx_ff == IDX_W'(NUM_ELEMENTS - 1));
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.div_sel  = DIV_MEAN;
      cmd.idx      = idx_ff;
      req_ready    = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load      = 1'b1;
               cmd.count_inc = req_update_stats;
               idx_in        = '0;
               state_in      = req_update_stats ? S_M_GO : S_Q_GO;
            end
         end
         S_M_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_M_WAIT;
         end
         S_M_WAIT: begin
            if (sts.div_done) begin
               state_in = S_M_MEAN;
            end
         end
         S_M_MEAN: begin
            cmd.mean_wr = 1'b1;
            state_in    = S_M_PROD;
         end
         S_M_PROD: begin
            cmd.prod_en = 1'b1;
            state_in    = S_M_SUM;
         end
         S_M_SUM: begin
            cmd.sum_wr = 1'b1;
            idx_in     = last ? '0 : idx_ff + 1'b1;
            state_in   = last ? S_Q_GO : S_M_GO;
         end
         S_Q_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VAR;
            state_in      = S_Q_WAIT;
         end
         S_Q_WAIT: begin
            if (sts.div_done) begin
               cmd.q_wr = 1'b1;
               idx_in   = last ? '0 : idx_ff + 1'b1;
               state_in = last ? S_O_SEL : S_Q_GO;
            end
         end
         S_O_SEL: begin
            state_in = sts.skip ? S_O_SKIP : S_R_GO;
         end
         S_O_SKIP: begin
            cmd.norm_skip_wr = 1'b1;
            idx_in           = last ? idx_ff : idx_ff + 1'b1;
            state_in         = last ? S_FIN : S_O_SEL;
         end
         S_R_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_R_WAIT;
         end
         S_R_WAIT: begin
            if (sts.sqrt_done) begin
               cmd.sd_wr = 1'b1;
               state_in  = S_D_GO;
            end
         end
         S_D_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_OUT;
            state_in      = S_D_WAIT;
         end
         S_D_WAIT: begin
            if (sts.div_done) begin
               cmd.norm_div_wr = 1'b1;
               idx_in          = last ? idx_ff : idx_ff + 1'b1;
               state_in        = last ? S_FIN : S_O_SEL;
            end
         end
         S_FIN: begin
            // The result register frees up in the same cycle its beat is taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== src/running_observation_normalizer.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// running_observation_normalizer
// Running mean and variance of a four-element observation, with normalization.
// -----------------------------------------------------------------------------
// Usage: one observation beat enters on req_* with a valid/ready handshake.
// With req_update_stats set the sample count, means and deviation sums are
// updated first; then every element is scaled by its running standard
// deviation into Q4.12, clamped to plus or minus ten. One result beat per
// observation leaves on rsp_*, with rsp_scaling_skipped set when some
// variance was zero and only the mean was removed.
// Work: the shared serial divider and the root unit run one element at a
// time. A skipped scaling saves the root and the final division. One item
// is in work at a time.
// req_ready is high only while the sequencer waits for work; a new beat is
// taken while the previous result still waits on rsp_ready, and that item
// holds at its end until the result register frees up.
// Reset: count one, means zero, deviation sums one, no result pending.
// -----------------------------------------------------------------------------
module running_observation_normalizer #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_update_stats,
   input  wire logic signed [SAMPLE_WIDTH-1:0]   req_sample_0,
   input  wire logic signed [SAMPLE_WIDTH-1:0]   req_sample_1,
   input  wire logic signed [SAMPLE_WIDTH-1:0]   req_sample_2,
   input  wire logic signed [SAMPLE_WIDTH-1:0]   req_sample_3,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [ron_pkg::NORM_W-1:0]     rsp_norm_0,
   output logic signed [ron_pkg::NORM_W-1:0]     rsp_norm_1,
   output logic signed [ron_pkg::NORM_W-1:0]     rsp_norm_2,
   output logic signed [ron_pkg::NORM_W-1:0]     rsp_norm_3,
   output logic                                  rsp_scaling_skipped
);
   import ron_pkg::*;

   ron_cmd_type              cmd;
   ron_sts_type              sts;
   logic signed [SAMPLE_WIDTH-1:0] samples [NUM_ELEMENTS];
   logic signed [NORM_W-1:0]       norms [NUM_ELEMENTS];

   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;

   ron_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_update_stats (req_update_stats),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .sts              (sts)
   );

   ron_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .sample_in (samples),
      .norm_out  (norms),
      .skip_out  (rsp_scaling_skipped)
   );

   assign rsp_norm_0 = norms[0];
   assign rsp_norm_1 = norms[1];
   assign rsp_norm_2 = norms[2];
   assign rsp_norm_3 = norms[3];

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   a_sqrt_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_start |-> !sts.sqrt_busy)
      else $error("root unit started while busy");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !cmd.publish)
      else $error("result published right after accept");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_norm_0 <= 17'sd40960) && (rsp_norm_0 >= -17'sd40960)))
      else $error("normalized output out of range");

endmodule
`default_nettype wire

// ===== bench/running_observation_normalizer_chk.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// running_observation_normalizer_chk
// Watches both channels, keeps its own running statistics and compares beats.
// -----------------------------------------------------------------------------
module running_observation_normalizer_chk (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire logic                                 req_update_stats,
   input  wire logic signed [15:0]                   req_sample_0,
   input  wire logic signed [15:0]                   req_sample_1,
   input  wire logic signed [15:0]                   req_sample_2,
   input  wire logic signed [15:0]                   req_sample_3,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic signed [ron_pkg::NORM_W-1:0]    rsp_norm_0,
   input  wire logic signed [ron_pkg::NORM_W-1:0]    rsp_norm_1,
   input  wire logic signed [ron_pkg::NORM_W-1:0]    rsp_norm_2,
   input  wire logic signed [ron_pkg::NORM_W-1:0]    rsp_norm_3,
   input  wire logic                                 rsp_scaling_skipped,
   output int                                        mismatch_count,
   output int                                        pending_count
);
   import ron_pkg::*;

   typedef struct {
      logic signed [NORM_W-1:0] norm [NUM_ELEMENTS];
      logic                     skipped;
   } norm_beat_type;

   localparam longint unsigned MAG_LIMIT = 64'hFFFF_FFFF;

   logic [COUNT_W-1:0]        obs_count;
   logic signed [MEAN_W-1:0]  run_mean [NUM_ELEMENTS];
   logic [SUM_W-1:0]          dev_sum  [NUM_ELEMENTS];
   norm_beat_type             expected_norms [$];

   function automatic longint unsigned abs_of(longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned round_div(longint unsigned m, longint unsigned d);
      return (m * 2 + d) / (d * 2);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Applies one observation to the running statistics when upd is set and normalizes it.
   task automatic predict_beat(input logic upd, input logic signed [15:0] smp [4],
                               output norm_beat_type res);
      longint            xq [NUM_ELEMENTS];
      longint            d, d2, nm, diff;
      longint unsigned   dm, m1, m2, p, pr, s, stp, cnt, q, sd, m, r;
      logic              skip;
      for (int i = 0; i < NUM_ELEMENTS; i++) xq[i] = longint'(smp[i]) * 65536;
      if (upd) begin
         if (obs_count != COUNT_MAX) obs_count = obs_count + 1;
         cnt = obs_count;
         for (int i = 0; i < NUM_ELEMENTS; i++) begin
            d   = xq[i] - longint'(run_mean[i]);
            dm  = abs_of(d);
            stp = round_div(dm, cnt);
            nm  = (d < 0) ? longint'(run_mean[i]) - longint'(stp)
                          : longint'(run_mean[i]) + longint'(stp);
            if (nm > 64'sh7FFF_FFFF) nm = 64'sh7FFF_FFFF;
            if (nm < -64'sh8000_0000) nm = -64'sh8000_0000;
            run_mean[i] = nm[31:0];
            d2 = xq[i] - nm;
            m1 = (dm > MAG_LIMIT) ? MAG_LIMIT : dm;
            m2 = abs_of(d2);
            if (m2 > MAG_LIMIT) m2 = MAG_LIMIT;
            p  = m1 * m2;
            pr = (p >> 16) + ((p >> 15) & 1);
            s  = dev_sum[i];
            if ((d < 0 && d2 > 0) || (d > 0 && d2 < 0)) begin
               s = (pr > s) ? 0 : s - pr;
            end else begin
               s = s + pr;
               if (s > SUM_MAX) s = SUM_MAX;
            end
            dev_sum[i] = s[SUM_W-1:0];
         end
      end
      cnt  = obs_count;
      skip = 1'b0;
      for (int i = 0; i < NUM_ELEMENTS; i++)
         if ((longint'(dev_sum[i]) / cnt) == 0) skip = 1'b1;
      for (int i = 0; i < NUM_ELEMENTS; i++) begin
         diff = xq[i] - longint'(run_mean[i]);
         m    = abs_of(diff);
         if (m > DIFF_MAX) m = DIFF_MAX;
         if (skip) begin
            r = round_div(m, 16);
         end else begin
            q  = longint'(dev_sum[i]) / cnt;
            sd = int_sqrt(q << 16);
            r  = round_div(m * 4096, sd);
         end
         if (r > OUT_LIMIT) r = OUT_LIMIT;
         res.norm[i] = (diff < 0) ? -$signed(r[NORM_W-1:0]) : $signed(r[NORM_W-1:0]);
      end
      res.skipped = skip;
   endtask

   always @(posedge clock) begin
      norm_beat_type           res;
      norm_beat_type           want;
      logic signed [15:0]      smp [4];
      logic signed [NORM_W-1:0] got [NUM_ELEMENTS];
      logic                    bad;
      if (reset) begin
         for (int i = 0; i < NUM_ELEMENTS; i++) begin
            run_mean[i] = '0;
            dev_sum[i]  = SUM_RESET;
         end
         obs_count = 1;
         expected_norms.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            smp = '{req_sample_0, req_sample_1, req_sample_2, req_sample_3};
            predict_beat(req_update_stats, smp, res);
            expected_norms.insert(expected_norms.size(), res);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_norm_0, rsp_norm_1, rsp_norm_2, rsp_norm_3};
            if (expected_norms.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result beat with nothing expected at %0t", $realtime);
            end else begin
               want = expected_norms.pop_front();
               bad  = (want.skipped !== rsp_scaling_skipped);
               for (int i = 0; i < NUM_ELEMENTS; i++)
                  if (want.norm[i] !== got[i]) bad = 1'b1;
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch at %0t: exp %0d %0d %0d %0d/%0b got %0d %0d %0d %0d/%0b",
                              $realtime, want.norm[0], want.norm[1], want.norm[2],
                              want.norm[3], want.skipped, got[0], got[1], got[2], got[3],
                              rsp_scaling_skipped);
               end
            end
         end
      end
      pending_count = expected_norms.size();
   end

endmodule

// ===== bench/running_observation_normalizer_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// running_observation_normalizer_tb
// Drives observation beats under varying idle and stall patterns and reports
// the verdict of the checker, which predicts every normalized result beat.
// -----------------------------------------------------------------------------
module running_observation_normalizer_tb;
   import ron_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_update_stats = 1'b0;
   logic signed [15:0] req_sample_0 = '0;
   logic signed [15:0] req_sample_1 = '0;
   logic signed [15:0] req_sample_2 = '0;
   logic signed [15:0] req_sample_3 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [NORM_W-1:0] rsp_norm_0, rsp_norm_1, rsp_norm_2, rsp_norm_3;
   logic rsp_scaling_skipped;
   int   mismatch_count;
   int   pending_count;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_orders   = 0;
   int   hold_seen     = 0;
   int   hold_left     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   running_observation_normalizer dut (
      .clock, .reset, .req_valid, .req_ready, .req_update_stats,
      .req_sample_0, .req_sample_1, .req_sample_2, .req_sample_3,
      .rsp_valid, .rsp_ready, .rsp_norm_0, .rsp_norm_1, .rsp_norm_2, .rsp_norm_3,
      .rsp_scaling_skipped
   );

   running_observation_normalizer_chk chk (
      .clock, .reset, .req_valid, .req_ready, .req_update_stats,
      .req_sample_0, .req_sample_1, .req_sample_2, .req_sample_3,
      .rsp_valid, .rsp_ready, .rsp_norm_0, .rsp_norm_1, .rsp_norm_2, .rsp_norm_3,
      .rsp_scaling_skipped, .mismatch_count, .pending_count
   );

   // Receiver: random stalls, plus a long hold-off whenever one is ordered.
   always @(posedge clock) begin
      if (hold_orders != hold_seen) begin
         hold_seen = hold_orders;
         hold_left = 4000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_beat(input logic upd, input logic signed [15:0] s0,
                            input logic signed [15:0] s1, input logic signed [15:0] s2,
                            input logic signed [15:0] s3);
      req_valid        <= 1'b1;
      req_update_stats <= upd;
      req_sample_0     <= s0;
      req_sample_1     <= s1;
      req_sample_2     <= s2;
      req_sample_3     <= s3;
      do @(posedge clock); while (!(req_valid && req_ready));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(400, 1)) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] pick_sample(input int center);
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3, 4: return 16'($urandom);
         default: return 16'(center + int'($urandom_range(64)) - 32);
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int center;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: normalize only at reset state, then a mix of updates and normalize-only beats, many at the extremes.
      send_beat(1'b0, 16'sh7FFF, 16'sh8000, 16'sh0000, -16'sh0001);
      send_beat(1'b1, 16'sh7FFF, 16'sh8000, 16'sh0000, -16'sh0001);
      send_beat(1'b1, 16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh5555);
      send_beat(1'b0, 16'sh7FFF, 16'sh8000, -16'sh2AAB, 16'sh0000);
      send_beat(1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_beat(1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_beat(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
      send_beat(1'b0, 16'sh0001, -16'sh0001, 16'sh0100, -16'sh0100);
      send_beat(1'b1, 16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005);
      send_beat(1'b1, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
      send_beat(1'b0, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh1234);

      // Sender pauses until every expected result has come back.
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 67 : 27) : 0;
         rsp_stall_pct = (phase == 2) ? 67 : ((phase == 3) ? 27 : 0);
         center = int'($urandom_range(2000)) - 1000;
         for (int n = 0; n < 200; n++) begin
            // The receiver holds off while beats keep coming, so the block fills.
            if (phase == 0 && n == 20) hold_orders++;
            if ($urandom_range(49) == 0) center = int'($urandom_range(60000)) - 30000;
            send_beat($urandom_range(3) != 0, pick_sample(center), pick_sample(center),
                      pick_sample(center), pick_sample(center));
         end
         if (phase == 1) wait_drained();
      end

      wait_drained();
      repeat (2000) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
